// File: sv/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg: shared definitions for the integer set table
// Field widths, operation and status codes, and default sizing used by the
// interfaces and the modules of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package ist_pkg;

  // Field widths of the request and response transactions.
  localparam int OPCODE_W = 1;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  // Default number of slots in the set.
  localparam int CAPACITY_DEFAULT = 64;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 1'b1;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_MISSING  = 3'd4
  } status_t;

endpackage

`default_nettype wire

// File: sv/ist_req_if.sv
// ----------------------------------------------------------------------------
// ist_req_if: request channel of the integer set table
// Valid/ready channel carrying one insert or remove operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ist_req_if;

  logic                             valid;
  logic                             ready;
  logic [ist_pkg::OPCODE_W-1:0]     opcode;
  logic signed [ist_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);

endinterface

`default_nettype wire

// File: sv/ist_rsp_if.sv
// ----------------------------------------------------------------------------
// ist_rsp_if: response channel of the integer set table
// Valid/ready channel carrying one status and element count per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ist_rsp_if;

  logic                         valid;
  logic                         ready;
  logic [ist_pkg::STATUS_W-1:0] status;
  logic [ist_pkg::COUNT_W-1:0]  element_count;

  modport source (output valid, output status, output element_count, input ready);
  modport sink   (input valid, input status, input element_count, output ready);

endinterface

`default_nettype wire

// File: sv/ist_ram.sv
// ----------------------------------------------------------------------------
// ist_ram: generic single-port synchronous RAM
// One access per cycle: a write, or a read whose data is registered and
// appears on the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share the one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: sv/integer_set_table.sv
// ----------------------------------------------------------------------------
// integer_set_table: bounded unordered set of signed 32-bit integers
// Each request inserts or removes one value; each produces one response with
// a status code and the number of values held afterwards.
// ----------------------------------------------------------------------------
// The slots live in one single-port RAM, each entry holding a value and its
// in-use mark. After reset the block runs a clearing pass over every RAM
// entry and takes no request until it ends. Every operation then scans all
// CAPACITY slots, reading one entry per cycle through the single RAM port,
// to find a matching value and the lowest free slot; the scan ends once the
// registered read data of the last slot has been compared. The done state
// then commits the write-back and loads the response register, waiting while
// the response register still holds a response not yet taken. Only then does
// the block return to idle and take the next request. A finished response
// may wait in its output register while the next request is accepted and
// scanned. The element count is reported modulo 128.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_set_table #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  ist_req_if.sink   req,
  ist_rsp_if.source rsp
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int EW    = ist_pkg::VALUE_W + 1;
  localparam int VW    = ist_pkg::VALUE_W;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                         state;
  logic [AW:0]                    cnt;
  logic                           pend;
  logic [AW-1:0]                  pend_addr;
  logic [ist_pkg::OPCODE_W-1:0]   op;
  logic [VW-1:0]                  value;
  logic                           hit_found;
  logic [AW-1:0]                  hit_idx;
  logic                           free_found;
  logic [AW-1:0]                  free_idx;
  logic [CW-1:0]                  held_count;
  logic [CW-1:0]                  held_count_next;
  logic                           rsp_valid;
  ist_pkg::status_t               status;
  ist_pkg::status_t               status_next;
  logic [31:0]                    count_ext;

  logic                           ram_we;
  logic [AW-1:0]                  ram_addr;
  logic [EW-1:0]                  ram_wdata;
  logic [EW-1:0]                  ram_rdata;

  logic                           issuing;
  logic                           commit;
  logic                           do_write;
  logic                           entry_used;
  logic [VW-1:0]                  entry_value;

  // Slot store: in-use mark in the top bit, value below it.
  ist_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign entry_used  = ram_rdata[EW-1];
  assign entry_value = ram_rdata[VW-1:0];

  // A read is issued each scan cycle until every slot has been addressed.
  assign issuing = (state == S_SCAN) && (cnt != (AW+1)'(CAPACITY));
  assign commit  = (state == S_DONE) && (!rsp_valid || rsp.ready);

  // Outcome of the operation once the scan has finished.
  always_comb begin
    status_next     = ist_pkg::ST_MISSING;
    held_count_next = held_count;
    do_write        = 1'b0;
    if (op == ist_pkg::OP_INSERT) begin
      if (hit_found) begin
        status_next = ist_pkg::ST_PRESENT;
      end else if (!free_found) begin
        status_next = ist_pkg::ST_FULL;
      end else begin
        status_next     = ist_pkg::ST_INSERTED;
        held_count_next = held_count + CW'(1);
        do_write        = 1'b1;
      end
    end else begin
      if (hit_found) begin
        status_next     = ist_pkg::ST_REMOVED;
        held_count_next = held_count - CW'(1);
        do_write        = 1'b1;
      end
    end
  end

  // RAM port arbitration: clearing pass, scan reads, or the final write-back.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cnt[AW-1:0];
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_DONE: begin
        if (op == ist_pkg::OP_INSERT) begin
          ram_addr  = free_idx;
          ram_wdata = {1'b1, value};
        end else begin
          ram_addr  = hit_idx;
          ram_wdata = {1'b0, value};
        end
        ram_we = commit && do_write;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control sequence: clear, wait for a request, scan, commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      pend       <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      held_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // The response register fills on commit and empties when taken.
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cnt[AW-1:0] == AW'(CAPACITY - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + (AW+1)'(1);
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cnt        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend <= issuing;
          if (issuing) begin
            cnt <= cnt + (AW+1)'(1);
          end
          // Compare the entry read in the previous cycle.
          if (pend) begin
            if (entry_used && (entry_value == value) && !hit_found) begin
              hit_found <= 1'b1;
            end
            if (!entry_used && !free_found) begin
              free_found <= 1'b1;
            end
          end
          if (!issuing && !pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            held_count <= held_count_next;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request capture, scan addresses and response.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op    <= req.opcode;
      value <= req.item_value;
    end
    if (issuing) begin
      pend_addr <= cnt[AW-1:0];
    end
    if (state == S_SCAN && pend) begin
      if (entry_used && (entry_value == value) && !hit_found) begin
        hit_idx <= pend_addr;
      end
      if (!entry_used && !free_found) begin
        free_idx <= pend_addr;
      end
    end
    if (commit) begin
      status <= status_next;
    end
  end

  // Channel outputs.
  assign count_ext         = 32'(held_count);
  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = status;
  assign rsp.element_count = count_ext[ist_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire
